@@ rtl/core/h2rgb_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_pkg
// Shared types, constants and elaboration-time tables for the HSL to RGB
// converter.
// ============================================================================
package h2rgb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int T_W    = 6;

    localparam int HUE_FULL = 360;
    localparam int SEXT_DEG = 60;
    localparam int PCT_FULL = 100;
    localparam int BYTE_MAX = 255;

    // stream word layout
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 32;
    localparam int S_HUE_LSB     = 0;
    localparam int S_SAT_LSB     = S_HUE_LSB + HUE_W;
    localparam int S_LIGHT_LSB   = S_SAT_LSB + PCT_W;
    localparam int S_ALPHA_LSB   = S_LIGHT_LSB + PCT_W;
    localparam int M_RED_LSB     = 0;
    localparam int M_GREEN_LSB   = M_RED_LSB + BYTE_W;
    localparam int M_BLUE_LSB    = M_GREEN_LSB + BYTE_W;
    localparam int M_ALPHA_LSB   = M_BLUE_LSB + BYTE_W;

    localparam int PCT_TBL_DEPTH = 2 ** PCT_W;

    typedef enum logic [2:0] {
        SX_RED_YEL = 3'd0,
        SX_YEL_GRN = 3'd1,
        SX_GRN_CYN = 3'd2,
        SX_CYN_BLU = 3'd3,
        SX_BLU_MAG = 3'd4,
        SX_MAG_RED = 3'd5
    } t_sext;

    typedef logic [63:0] t_pct_tbl [PCT_TBL_DEPTH];

    // percent -> fixed point, rounded; codes above full scale saturate
    function automatic t_pct_tbl pct_tbl(input int unsigned frac);
        t_pct_tbl    tbl;
        logic [63:0] p;
        for (int i = 0; i < PCT_TBL_DEPTH; i++) begin
            p      = (i > PCT_FULL) ? 64'(PCT_FULL) : 64'(i);
            tbl[i] = (p * (64'd1 << frac) + 64'(PCT_FULL / 2)) / 64'(PCT_FULL);
        end
        return tbl;
    endfunction

endpackage

@@ rtl/core/h2rgb_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_front
// Stages 1-2: hue wrap and sextant split, percent to fixed point, and the
// lightness distance term D = ONE - |2L - ONE|.
// ============================================================================
module h2rgb_front #(
    parameter int FRAC_BITS = h2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [h2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic [h2rgb_pkg::PCT_W-1:0]     i_saturation,
    input  logic [h2rgb_pkg::PCT_W-1:0]     i_lightness,
    input  logic [h2rgb_pkg::BYTE_W-1:0]    i_alpha,
    output logic                            o_valid,
    input  logic                            i_ready,
    output h2rgb_pkg::t_sext                o_sext,
    output logic [h2rgb_pkg::T_W-1:0]       o_t,
    output logic [FRAC_BITS:0]              o_lf,
    output logic [FRAC_BITS:0]              o_sf,
    output logic [FRAC_BITS:0]              o_d,
    output logic [h2rgb_pkg::BYTE_W-1:0]    o_alpha
);

    localparam int W  = FRAC_BITS + 1;
    localparam int HW = h2rgb_pkg::HUE_W;
    localparam int TW = h2rgb_pkg::T_W;
    localparam h2rgb_pkg::t_pct_tbl PCT_TBL = h2rgb_pkg::pct_tbl(FRAC_BITS);

    logic w_rdy1, w_rdy2;

    logic                          r_s1_vld;
    h2rgb_pkg::t_sext              r_s1_sext;
    logic [TW-1:0]                 r_s1_t;
    logic [W-1:0]                  r_s1_lf;
    logic [W-1:0]                  r_s1_sf;
    logic [h2rgb_pkg::BYTE_W-1:0]  r_s1_alpha;

    logic                          r_s2_vld;
    h2rgb_pkg::t_sext              r_s2_sext;
    logic [TW-1:0]                 r_s2_t;
    logic [W-1:0]                  r_s2_lf;
    logic [W-1:0]                  r_s2_sf;
    logic [W-1:0]                  r_s2_d;
    logic [h2rgb_pkg::BYTE_W-1:0]  r_s2_alpha;

    logic [HW-1:0]                 n_hue_w;
    logic [HW-1:0]                 n_base;
    logic [TW-1:0]                 n_rem;
    h2rgb_pkg::t_sext              n_s1_sext;
    logic [TW-1:0]                 n_s1_t;

    logic [W:0]                    n_twol;
    logic [W:0]                    n_one;
    logic [W:0]                    n_dist;
    logic [W-1:0]                  n_s2_d;

    assign w_rdy2  = !r_s2_vld || i_ready;
    assign w_rdy1  = !r_s1_vld || w_rdy2;
    assign o_ready = w_rdy1;

    // stage 1: hue wrap, sextant and position within it
    always_comb begin
        n_hue_w = (i_hue >= HW'(h2rgb_pkg::HUE_FULL)) ?
                  i_hue - HW'(h2rgb_pkg::HUE_FULL) : i_hue;
        if (n_hue_w >= HW'(5 * h2rgb_pkg::SEXT_DEG)) begin
            n_s1_sext = h2rgb_pkg::SX_MAG_RED;
            n_base    = HW'(5 * h2rgb_pkg::SEXT_DEG);
        end else if (n_hue_w >= HW'(4 * h2rgb_pkg::SEXT_DEG)) begin
            n_s1_sext = h2rgb_pkg::SX_BLU_MAG;
            n_base    = HW'(4 * h2rgb_pkg::SEXT_DEG);
        end else if (n_hue_w >= HW'(3 * h2rgb_pkg::SEXT_DEG)) begin
            n_s1_sext = h2rgb_pkg::SX_CYN_BLU;
            n_base    = HW'(3 * h2rgb_pkg::SEXT_DEG);
        end else if (n_hue_w >= HW'(2 * h2rgb_pkg::SEXT_DEG)) begin
            n_s1_sext = h2rgb_pkg::SX_GRN_CYN;
            n_base    = HW'(2 * h2rgb_pkg::SEXT_DEG);
        end else if (n_hue_w >= HW'(h2rgb_pkg::SEXT_DEG)) begin
            n_s1_sext = h2rgb_pkg::SX_YEL_GRN;
            n_base    = HW'(h2rgb_pkg::SEXT_DEG);
        end else begin
            n_s1_sext = h2rgb_pkg::SX_RED_YEL;
            n_base    = '0;
        end
        n_rem = TW'(n_hue_w - n_base);
        case (n_s1_sext)
            h2rgb_pkg::SX_YEL_GRN,
            h2rgb_pkg::SX_CYN_BLU,
            h2rgb_pkg::SX_MAG_RED: begin
                n_s1_t = TW'(h2rgb_pkg::SEXT_DEG) - n_rem;
            end
            default: begin
                n_s1_t = n_rem;
            end
        endcase
    end

    // stage 2: D = ONE - |2L - ONE|
    always_comb begin
        n_one  = (W + 1)'(1) << FRAC_BITS;
        n_twol = {r_s1_lf, 1'b0};
        n_dist = (n_twol >= n_one) ? n_twol - n_one : n_one - n_twol;
        n_s2_d = (n_dist >= n_one) ? '0 : W'(n_one - n_dist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_vld <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_sext  <= n_s1_sext;
            r_s1_t     <= n_s1_t;
            r_s1_lf    <= W'(PCT_TBL[i_lightness]);
            r_s1_sf    <= W'(PCT_TBL[i_saturation]);
            r_s1_alpha <= i_alpha;
        end
        if (w_rdy2) begin
            r_s2_sext  <= r_s1_sext;
            r_s2_t     <= r_s1_t;
            r_s2_lf    <= r_s1_lf;
            r_s2_sf    <= r_s1_sf;
            r_s2_d     <= n_s2_d;
            r_s2_alpha <= r_s1_alpha;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_sext  = r_s2_sext;
    assign o_t     = r_s2_t;
    assign o_lf    = r_s2_lf;
    assign o_sf    = r_s2_sf;
    assign o_d     = r_s2_d;
    assign o_alpha = r_s2_alpha;

endmodule

@@ rtl/core/h2rgb_chroma.sv @@
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_chroma
// Stages 3-5: chroma C, offset m, and the secondary component X by a
// reciprocal multiply for the divide by 60.
// ============================================================================
module h2rgb_chroma #(
    parameter int FRAC_BITS = h2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  h2rgb_pkg::t_sext                i_sext,
    input  logic [h2rgb_pkg::T_W-1:0]       i_t,
    input  logic [FRAC_BITS:0]              i_lf,
    input  logic [FRAC_BITS:0]              i_sf,
    input  logic [FRAC_BITS:0]              i_d,
    input  logic [h2rgb_pkg::BYTE_W-1:0]    i_alpha,
    output logic                            o_valid,
    input  logic                            i_ready,
    output h2rgb_pkg::t_sext                o_sext,
    output logic [FRAC_BITS:0]              o_c,
    output logic [FRAC_BITS:0]              o_x,
    output logic [FRAC_BITS:0]              o_m,
    output logic [h2rgb_pkg::BYTE_W-1:0]    o_alpha
);

    localparam int W    = FRAC_BITS + 1;
    localparam int TW   = h2rgb_pkg::T_W;
    localparam int PW   = 2 * W;
    localparam int YW   = FRAC_BITS + 7;
    // (C*t + 30) / 60 == ((C*t + 30) >> 2) / 15
    localparam int ZW   = FRAC_BITS + 4;
    localparam int XDIV = h2rgb_pkg::SEXT_DEG / 4;
    localparam int KSH  = ZW + $clog2(XDIV);
    localparam int RW   = FRAC_BITS + 5;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << KSH) / 64'(XDIV) + 64'd1);
    localparam int QW   = ZW + RW;

    logic w_rdy3, w_rdy4, w_rdy5;

    logic                          r_s3_vld;
    h2rgb_pkg::t_sext              r_s3_sext;
    logic [TW-1:0]                 r_s3_t;
    logic [W-1:0]                  r_s3_lf;
    logic [W-1:0]                  r_s3_c;
    logic [h2rgb_pkg::BYTE_W-1:0]  r_s3_alpha;

    logic                          r_s4_vld;
    h2rgb_pkg::t_sext              r_s4_sext;
    logic [W-1:0]                  r_s4_c;
    logic [ZW-1:0]                 r_s4_z;
    logic [W-1:0]                  r_s4_m;
    logic [h2rgb_pkg::BYTE_W-1:0]  r_s4_alpha;

    logic                          r_s5_vld;
    h2rgb_pkg::t_sext              r_s5_sext;
    logic [W-1:0]                  r_s5_c;
    logic [W-1:0]                  r_s5_x;
    logic [W-1:0]                  r_s5_m;
    logic [h2rgb_pkg::BYTE_W-1:0]  r_s5_alpha;

    logic [PW-1:0]                 n_prod;
    logic [W-1:0]                  n_s3_c;
    logic [YW-1:0]                 n_y;
    logic [W-1:0]                  n_half_c;
    logic [W-1:0]                  n_s4_m;
    logic [QW-1:0]                 n_q;
    logic [W-1:0]                  n_s5_x;

    assign w_rdy5  = !r_s5_vld || i_ready;
    assign w_rdy4  = !r_s4_vld || w_rdy5;
    assign w_rdy3  = !r_s3_vld || w_rdy4;
    assign o_ready = w_rdy3;

    always_comb begin
        // C = (D * S + ONE/2) >> FRAC_BITS
        n_prod   = PW'(i_d) * PW'(i_sf) + (PW'(1) << (FRAC_BITS - 1));
        n_s3_c   = n_prod[FRAC_BITS +: W];
        // C*t + 30, then m = L - C/2 floored at zero
        n_y      = YW'(r_s3_c) * YW'(r_s3_t) + YW'(h2rgb_pkg::SEXT_DEG / 2);
        n_half_c = r_s3_c >> 1;
        n_s4_m   = (r_s3_lf >= n_half_c) ? r_s3_lf - n_half_c : '0;
        // exact divide by 15
        n_q      = QW'(r_s4_z) * QW'(RECIP);
        n_s5_x   = n_q[KSH +: W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_s3_vld <= i_valid;
            end
            if (w_rdy4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (w_rdy5) begin
                r_s5_vld <= r_s4_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_sext  <= i_sext;
            r_s3_t     <= i_t;
            r_s3_lf    <= i_lf;
            r_s3_c     <= n_s3_c;
            r_s3_alpha <= i_alpha;
        end
        if (w_rdy4) begin
            r_s4_sext  <= r_s3_sext;
            r_s4_c     <= r_s3_c;
            r_s4_z     <= n_y[2 +: ZW];
            r_s4_m     <= n_s4_m;
            r_s4_alpha <= r_s3_alpha;
        end
        if (w_rdy5) begin
            r_s5_sext  <= r_s4_sext;
            r_s5_c     <= r_s4_c;
            r_s5_x     <= n_s5_x;
            r_s5_m     <= r_s4_m;
            r_s5_alpha <= r_s4_alpha;
        end
    end

    assign o_valid = r_s5_vld;
    assign o_sext  = r_s5_sext;
    assign o_c     = r_s5_c;
    assign o_x     = r_s5_x;
    assign o_m     = r_s5_m;
    assign o_alpha = r_s5_alpha;

endmodule

@@ rtl/core/h2rgb_mix.sv @@
`timescale 1ns / 1ps
// ============================================================================
// h2rgb_mix
// Stages 6-7: route C and X to channels by sextant, add m, scale to a byte
// with round to nearest and clamp. Stage 7 is the output register.
// ============================================================================
module h2rgb_mix #(
    parameter int FRAC_BITS = h2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  h2rgb_pkg::t_sext                i_sext,
    input  logic [FRAC_BITS:0]              i_c,
    input  logic [FRAC_BITS:0]              i_x,
    input  logic [FRAC_BITS:0]              i_m,
    input  logic [h2rgb_pkg::BYTE_W-1:0]    i_alpha,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [h2rgb_pkg::BYTE_W-1:0]    o_red,
    output logic [h2rgb_pkg::BYTE_W-1:0]    o_green,
    output logic [h2rgb_pkg::BYTE_W-1:0]    o_blue,
    output logic [h2rgb_pkg::BYTE_W-1:0]    o_alpha
);

    localparam int W  = FRAC_BITS + 1;
    localparam int VW = FRAC_BITS + 2;
    localparam int BW = h2rgb_pkg::BYTE_W;
    localparam int SW = VW + BW;
    localparam int EW = SW - FRAC_BITS;

    logic w_rdy6, w_rdy7;

    logic            r_s6_vld;
    logic [VW-1:0]   r_s6_r;
    logic [VW-1:0]   r_s6_g;
    logic [VW-1:0]   r_s6_b;
    logic [BW-1:0]   r_s6_alpha;

    logic            r_s7_vld;
    logic [BW-1:0]   r_s7_r;
    logic [BW-1:0]   r_s7_g;
    logic [BW-1:0]   r_s7_b;
    logic [BW-1:0]   r_s7_alpha;

    logic [W-1:0]    n_cr, n_cg, n_cb;
    logic [BW-1:0]   n_s7_r, n_s7_g, n_s7_b;

    function automatic logic [BW-1:0] to_byte(input logic [VW-1:0] v);
        logic [SW-1:0] s;
        logic [EW-1:0] e;
        // v*255 + ONE/2
        s = {v, BW'(0)} - SW'(v) + (SW'(1) << (FRAC_BITS - 1));
        e = s[FRAC_BITS +: EW];
        return (e > EW'(h2rgb_pkg::BYTE_MAX)) ? BW'(h2rgb_pkg::BYTE_MAX) : BW'(e);
    endfunction

    assign w_rdy7  = !r_s7_vld || i_ready;
    assign w_rdy6  = !r_s6_vld || w_rdy7;
    assign o_ready = w_rdy6;

    always_comb begin
        case (i_sext)
            h2rgb_pkg::SX_RED_YEL: begin
                n_cr = i_c; n_cg = i_x; n_cb = '0;
            end
            h2rgb_pkg::SX_YEL_GRN: begin
                n_cr = i_x; n_cg = i_c; n_cb = '0;
            end
            h2rgb_pkg::SX_GRN_CYN: begin
                n_cr = '0;  n_cg = i_c; n_cb = i_x;
            end
            h2rgb_pkg::SX_CYN_BLU: begin
                n_cr = '0;  n_cg = i_x; n_cb = i_c;
            end
            h2rgb_pkg::SX_BLU_MAG: begin
                n_cr = i_x; n_cg = '0;  n_cb = i_c;
            end
            default: begin
                n_cr = i_c; n_cg = '0;  n_cb = i_x;
            end
        endcase
        n_s7_r = to_byte(r_s6_r);
        n_s7_g = to_byte(r_s6_g);
        n_s7_b = to_byte(r_s6_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            if (w_rdy6) begin
                r_s6_vld <= i_valid;
            end
            if (w_rdy7) begin
                r_s7_vld <= r_s6_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy6) begin
            r_s6_r     <= VW'(n_cr) + VW'(i_m);
            r_s6_g     <= VW'(n_cg) + VW'(i_m);
            r_s6_b     <= VW'(n_cb) + VW'(i_m);
            r_s6_alpha <= i_alpha;
        end
        if (w_rdy7) begin
            r_s7_r     <= n_s7_r;
            r_s7_g     <= n_s7_g;
            r_s7_b     <= n_s7_b;
            r_s7_alpha <= r_s6_alpha;
        end
    end

    assign o_valid = r_s7_vld;
    assign o_red   = r_s7_r;
    assign o_green = r_s7_g;
    assign o_blue  = r_s7_b;
    assign o_alpha = r_s7_alpha;

endmodule

@@ rtl/core/hsl_to_rgb_converter_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsl_to_rgb_converter_unit
// Pixel stream converter from hue/saturation/lightness plus alpha to RGBA.
//
// Slave stream: one pixel per word (hue in degrees, saturation and lightness
// in percent, alpha byte). Master stream: one RGBA word per input word, in
// input order. Hue 360..511 wraps by 360; percent codes above 100 saturate.
// Throughput: one word per clock while the receiver is ready, set by the
// 7-stage pipeline; each stage holds one word and carries its own valid bit.
// Stage 7 is the output register. When the receiver stalls the output word
// holds; words behind it keep moving into empty stages, and o_s_axis_tready
// drops only once every stage is full. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline; no words are output
// until new input is accepted.
// ============================================================================
module hsl_to_rgb_converter_unit #(
    parameter int FRAC_BITS = h2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [8:0] hue, [15:9] saturation, [22:16] lightness, [30:23] alpha
    input  logic [h2rgb_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha_out
    output logic [h2rgb_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int BW = h2rgb_pkg::BYTE_W;

    logic               w_f_valid, w_f_ready;
    h2rgb_pkg::t_sext   w_f_sext;
    logic [h2rgb_pkg::T_W-1:0] w_f_t;
    logic [FRAC_BITS:0] w_f_lf, w_f_sf, w_f_d;
    logic [BW-1:0]      w_f_alpha;

    logic               w_c_valid, w_c_ready;
    h2rgb_pkg::t_sext   w_c_sext;
    logic [FRAC_BITS:0] w_c_c, w_c_x, w_c_m;
    logic [BW-1:0]      w_c_alpha;

    logic [BW-1:0]      w_red, w_green, w_blue, w_alpha;

    h2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_hue        (i_s_axis_tdata[h2rgb_pkg::S_HUE_LSB +: h2rgb_pkg::HUE_W]),
        .i_saturation (i_s_axis_tdata[h2rgb_pkg::S_SAT_LSB +: h2rgb_pkg::PCT_W]),
        .i_lightness  (i_s_axis_tdata[h2rgb_pkg::S_LIGHT_LSB +: h2rgb_pkg::PCT_W]),
        .i_alpha      (i_s_axis_tdata[h2rgb_pkg::S_ALPHA_LSB +: BW]),
        .o_valid      (w_f_valid),
        .i_ready      (w_f_ready),
        .o_sext       (w_f_sext),
        .o_t          (w_f_t),
        .o_lf         (w_f_lf),
        .o_sf         (w_f_sf),
        .o_d          (w_f_d),
        .o_alpha      (w_f_alpha)
    );

    h2rgb_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_sext  (w_f_sext),
        .i_t     (w_f_t),
        .i_lf    (w_f_lf),
        .i_sf    (w_f_sf),
        .i_d     (w_f_d),
        .i_alpha (w_f_alpha),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_sext  (w_c_sext),
        .o_c     (w_c_c),
        .o_x     (w_c_x),
        .o_m     (w_c_m),
        .o_alpha (w_c_alpha)
    );

    h2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_sext  (w_c_sext),
        .i_c     (w_c_c),
        .i_x     (w_c_x),
        .i_m     (w_c_m),
        .i_alpha (w_c_alpha),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue),
        .o_alpha (w_alpha)
    );

    assign o_m_axis_tdata = {w_alpha, w_blue, w_green, w_red};

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while pipeline output is empty");

    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while receiver is ready");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    a_x_within_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_c_valid |-> (w_c_x <= w_c_c))
        else $error("secondary component exceeds chroma");

endmodule
